// File: rtl/llss_pkg.sv
// ---------------------------------------------------------------------------
// llss_pkg
// types and codes used by the slot scheduler, including the word of its count store
// ---------------------------------------------------------------------------
package llss_pkg;

  localparam int CNT_W  = 14;
  localparam int SLOT_W = 4;
  localparam int CFG_W  = 5;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic              is_active;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] assigned_slot;
    logic [STAT_W-1:0] status;
    logic              slot_is_current;
    logic [SLOT_W-1:0] current_slot;
    logic [CNT_W-1:0]  total_clients;
  } out_item_t;

  // one word of the per-slot count store
  typedef struct packed {
    logic [CNT_W-1:0] clients;
    logic [CNT_W-1:0] active;
  } slot_cnt_t;

endpackage

// File: rtl/llss_ram.sv
// ---------------------------------------------------------------------------
// llss_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module llss_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/least_loaded_slot_scheduler.sv
// ---------------------------------------------------------------------------
// least_loaded_slot_scheduler
// time-slot load balancer with per-slot client and active-client counts
// ---------------------------------------------------------------------------
// usage
//   in_*  : one command per transfer (tick, add client, remove client)
//   out_* : one result per command, held in an output register
//   cfg_* : write of slot_count; clears every count, the total and the
//           current slot at once through the per-slot valid bits
// steps per command
//   tick, unused command, out-of-range remove : final step, then the output
//   remove : one count store read, one read-modify-write, then the final step
//   add    : a scan reads one slot of the count store per cycle, and the shared
//            compare unit checks each registered read; the chosen slot is
//            then written, or no slot is reported when none is below the limit
//   one command is in work at a time; in_stall is high from acceptance until
//   the result has been moved into the output register, and while a cfg
//   transfer is on offer so that a command never meets a half-done clear
// reset clears the sequencer, the valid bits, the current slot, the total and
// sets slot_count to its default; no clearing pass is needed
// a stalled output holds its result; a finished command waits in its last
// step until the output register is free
// ---------------------------------------------------------------------------
module least_loaded_slot_scheduler #(
  parameter int MAX_SLOTS      = 16,
  parameter int PER_SLOT_LIMIT = 10000
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  llss_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output llss_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [llss_pkg::CFG_W-1:0] cfg_data
);

  import llss_pkg::*;

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCAN_W = $clog2(MAX_SLOTS + 1);
  localparam int WORD_W = $bits(slot_cnt_t);
  localparam logic [CFG_W-1:0] RESET_SLOTS =
    (MAX_SLOTS < 16) ? CFG_W'(MAX_SLOTS) : CFG_W'(16);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(PER_SLOT_LIMIT);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_ADD_WR = 3'd2;
  localparam logic [2:0] S_RM_CHK = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     slot_count_r, slot_count_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [MAX_SLOTS-1:0] valid_r, valid_nxt;

  // per-command working registers
  logic                 act_r, act_nxt;
  logic                 is_cur_r, is_cur_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [SLOT_W-1:0]    assigned_r, assigned_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [CNT_W-1:0]     best_num_r, best_num_nxt;
  logic [CNT_W-1:0]     best_act_r, best_act_nxt;
  logic                 found_r, found_nxt;
  logic [SCAN_W-1:0]    scan_r, scan_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  // count store ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  slot_cnt_t            ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  slot_cnt_t            ram_rdata;
  logic [WORD_W-1:0]    ram_rd_raw;

  logic                 in_xfer;
  logic                 cfg_xfer;
  logic                 out_free;
  logic                 scan_issue;
  logic [CNT_W-1:0]     rd_clients;
  logic [CNT_W-1:0]     rd_active;

  llss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd_raw)
  );

  assign ram_rdata = slot_cnt_t'(ram_rd_raw);

  // a pending cfg transfer takes the idle cycle before any command
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // scan issues one read per cycle while slots remain
  assign scan_issue = (state_r == S_SCAN) && (32'(scan_r) < 32'(slot_count_r));
  // a slot never written since the last clear reads as zero
  assign rd_clients = valid_r[rd_idx_r] ? ram_rdata.clients : '0;
  assign rd_active  = valid_r[rd_idx_r] ? ram_rdata.active  : '0;
  assign ram_raddr  = (state_r == S_SCAN) ? scan_r[IDX_W-1:0] : IDX_W'(in_data.slot);

  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = slot_count_r;
    cur_nxt        = cur_r;
    total_nxt      = total_r;
    valid_nxt      = valid_r;
    act_nxt        = act_r;
    is_cur_nxt     = is_cur_r;
    status_nxt     = status_r;
    assigned_nxt   = assigned_r;
    best_nxt       = best_r;
    best_num_nxt   = best_num_r;
    best_act_nxt   = best_act_r;
    found_nxt      = found_r;
    scan_nxt       = scan_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = best_r;
    ram_wdata      = '{clients: rd_clients, active: rd_active};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_xfer) begin
          // oversized counts are clamped to the slots that exist
          if (32'(cfg_data) > 32'(MAX_SLOTS)) begin
            slot_count_nxt = CFG_W'(MAX_SLOTS);
          end else begin
            slot_count_nxt = cfg_data;
          end
          valid_nxt = '0;
          cur_nxt   = '0;
          total_nxt = '0;
        end
        if (in_xfer) begin
          act_nxt      = in_data.is_active;
          is_cur_nxt   = (32'(in_data.slot) == 32'(cur_r));
          status_nxt   = ST_OK;
          assigned_nxt = '0;
          best_nxt     = IDX_W'(in_data.slot);
          rd_idx_nxt   = IDX_W'(in_data.slot);
          case (in_data.cmd)
            CMD_TICK: begin
              if (32'(cur_r) + 32'd1 >= 32'(slot_count_r)) begin
                cur_nxt = '0;
              end else begin
                cur_nxt = cur_r + 1'b1;
              end
              state_nxt = S_DONE;
            end
            CMD_ADD: begin
              best_nxt     = '0;
              best_num_nxt = LIMIT;
              best_act_nxt = '0;
              found_nxt    = 1'b0;
              scan_nxt     = '0;
              state_nxt    = S_SCAN;
            end
            CMD_REMOVE: begin
              if (32'(in_data.slot) >= 32'(slot_count_r)) begin
                status_nxt = ST_OUT_RANGE;
                state_nxt  = S_DONE;
              end else begin
                // read issued this cycle, data checked next
                state_nxt = S_RM_CHK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_issue) begin
          scan_nxt   = scan_r + 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_r[IDX_W-1:0];
        end
        // shared compare: strict less keeps the lowest-numbered slot on ties
        if (rd_vld_r && (rd_clients < best_num_r)) begin
          best_nxt     = rd_idx_r;
          best_num_nxt = rd_clients;
          best_act_nxt = rd_active;
          found_nxt    = 1'b1;
        end
        if (!scan_issue && !rd_vld_r) begin
          if (found_r) begin
            state_nxt = S_ADD_WR;
          end else begin
            status_nxt = ST_NO_SLOT;
            state_nxt  = S_DONE;
          end
        end
      end

      S_ADD_WR: begin
        ram_we            = 1'b1;
        ram_wdata.clients = best_num_r + 1'b1;
        ram_wdata.active  = (act_r && (best_act_r < COUNT_MAX)) ?
                            best_act_r + 1'b1 : best_act_r;
        valid_nxt[best_r] = 1'b1;
        assigned_nxt      = SLOT_W'(best_r);
        if (total_r < COUNT_MAX) begin
          total_nxt = total_r + 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_RM_CHK: begin
        if (rd_clients == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_we            = 1'b1;
          ram_wdata.clients = rd_clients - 1'b1;
          ram_wdata.active  = (act_r && (rd_active != '0)) ?
                              rd_active - 1'b1 : rd_active;
          valid_nxt[best_r] = 1'b1;
          if (total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // wait here while the previous result is still held
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.assigned_slot   = assigned_r;
          out_nxt.status          = status_r;
          out_nxt.slot_is_current = is_cur_r;
          out_nxt.current_slot    = SLOT_W'(cur_r);
          out_nxt.total_clients   = total_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= RESET_SLOTS;
      cur_r        <= '0;
      total_r      <= '0;
      valid_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      cur_r        <= cur_nxt;
      total_r      <= total_nxt;
      valid_r      <= valid_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    is_cur_r   <= is_cur_nxt;
    status_r   <= status_nxt;
    assigned_r <= assigned_nxt;
    best_r     <= best_nxt;
    best_num_r <= best_num_nxt;
    best_act_r <= best_act_nxt;
    found_r    <= found_nxt;
    scan_r     <= scan_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_r      <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  // current slot stays inside the slots in use
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_r) < 32'(slot_count_r)) || (cur_r == '0))
    else $error("current slot outside slot_count");

  // the count store is only written by the two update steps
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_ADD_WR) || (state_r == S_RM_CHK))
    else $error("count store written outside an update step");

  // an add only updates a slot that was below the limit
  a_add_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_WR) |-> (best_num_r < LIMIT) && found_r)
    else $error("add chose a full slot");

  // a new result only comes out of the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the final step");
`endif

endmodule
